// ===== src/mnep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note event parser package
// Shared constants, types and the result record handed between stages.
// ----------------------------------------------------------------------------
package mnep_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NoteW  = 7;
  localparam int unsigned ChanW  = 5;
  localparam int unsigned TdataW = 16;

  // Upper nibbles of the status byte that matter here.
  localparam logic [3:0] KindNoteOff   = 4'h8;
  localparam logic [3:0] KindNoteOn    = 4'h9;
  localparam logic [3:0] KindPolyPress = 4'hA;
  localparam logic [3:0] KindCtrl      = 4'hB;
  localparam logic [3:0] KindProgram   = 4'hC;
  localparam logic [3:0] KindChanPress = 4'hD;
  localparam logic [3:0] KindPitchBend = 4'hE;

  // Whole system bytes with special handling.
  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] TimeCodeQtr  = 8'hF1;
  localparam logic [7:0] SongPosition = 8'hF2;
  localparam logic [7:0] SongSelect   = 8'hF3;
  localparam logic [7:0] SysexEnd     = 8'hF7;

  typedef struct packed {
    logic             valid;
    logic             is_note_on;
    logic [NoteW-1:0] note_number;
    logic [NoteW-1:0] note_velocity;
  } mnep_event_t;

endpackage
`default_nettype wire

// ===== src/mnep_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note event parser input stage
// Registers one incoming byte; takes a new one when empty or as the held byte moves on.
// ----------------------------------------------------------------------------
module mnep_in_stage
  import mnep_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             advance_i,
  output logic                  held_valid_o,
  output logic [ByteW-1:0]      held_byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule
`default_nettype wire

// ===== src/mnep_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note event parser core
// Holds the parse state and the channel filter, decodes one byte per advance.
// ----------------------------------------------------------------------------
module mnep_parser
  import mnep_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_write_i,
  input  wire logic [ChanW-1:0] cfg_data_i,
  input  wire logic             advance_i,
  input  wire logic [ByteW-1:0] byte_i,
  output mnep_event_t           event_o
);

  typedef enum logic [5:0] {
    PhIdle    = 6'b000001,
    PhSkip    = 6'b000010,
    PhOnNote  = 6'b000100,
    PhOnVel   = 6'b001000,
    PhOffNote = 6'b010000,
    PhOffTail = 6'b100000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       skip_q, skip_d;
  logic             sysex_q, sysex_d;
  logic [NoteW-1:0] pend_q, pend_d;
  logic [ChanW-1:0] chan_sel_q;

  logic [3:0] kind;
  logic [3:0] chan;
  logic       chan_match;
  logic [1:0] skip_dec;

  assign kind       = byte_i[7:4];
  assign chan       = byte_i[3:0];
  // A negative selection (sign bit set) accepts every channel.
  assign chan_match = chan_sel_q[ChanW-1] || (chan_sel_q[3:0] == chan);
  assign skip_dec   = (skip_q != 2'd0) ? (skip_q - 2'd1) : 2'd0;

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    sysex_d = sysex_q;
    pend_d  = pend_q;
    event_o = '0;

    case (phase_q)
      PhSkip: begin
        skip_d = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_d = PhIdle;
        end
      end
      PhOnNote: begin
        pend_d  = byte_i[NoteW-1:0];
        phase_d = PhOnVel;
      end
      PhOnVel: begin
        phase_d               = PhIdle;
        event_o.valid         = 1'b1;
        event_o.note_number   = pend_q;
        // The full byte decides; a set top bit still counts as a note-on.
        event_o.is_note_on    = (byte_i != '0);
        event_o.note_velocity = byte_i[NoteW-1:0];
      end
      PhOffNote: begin
        pend_d              = byte_i[NoteW-1:0];
        phase_d             = PhOffTail;
        event_o.valid       = 1'b1;
        event_o.note_number = byte_i[NoteW-1:0];
      end
      default: begin
        // Idle and the note-off tail; in the tail a data byte is dropped, a status byte is parsed.
        phase_d = PhIdle;
        if (phase_q == PhOffTail && !byte_i[7]) begin
          phase_d = PhIdle;
        end else if (byte_i == SysexEnd) begin
          sysex_d = 1'b0;
        end else if (!sysex_q) begin
          case (kind)
            KindNoteOn: begin
              if (chan_match) begin
                phase_d = PhOnNote;
              end
            end
            KindNoteOff: begin
              if (chan_match) begin
                phase_d = PhOffNote;
              end
            end
            KindPolyPress, KindCtrl, KindPitchBend: begin
              phase_d = PhSkip;
              skip_d  = 2'd2;
            end
            KindProgram, KindChanPress: begin
              phase_d = PhSkip;
              skip_d  = 2'd1;
            end
            default: begin
              if (byte_i == TimeCodeQtr || byte_i == SongSelect) begin
                phase_d = PhSkip;
                skip_d  = 2'd1;
              end else if (byte_i == SongPosition) begin
                phase_d = PhSkip;
                skip_d  = 2'd2;
              end else if (byte_i == SysexStart) begin
                sysex_d = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      skip_q     <= 2'd0;
      sysex_q    <= 1'b0;
      pend_q     <= '0;
      chan_sel_q <= '1;
    end else begin
      if (cfg_write_i) begin
        chan_sel_q <= cfg_data_i;
      end
      if (advance_i) begin
        phase_q <= phase_d;
        skip_q  <= skip_d;
        sysex_q <= sysex_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mnep_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note event parser output stage
// Result register that holds a note event until the sink takes it.
// ----------------------------------------------------------------------------
module mnep_out_stage
  import mnep_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mnep_event_t  event_i,
  input  wire logic         advance_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output mnep_event_t       event_o
);

  logic        valid_q, valid_d;
  mnep_event_t event_q;
  logic        load;

  assign free_o = !valid_q || out_ready_i;
  assign load   = advance_i && event_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      event_q <= event_i;
    end
  end

  assign out_valid_o = valid_q;
  assign event_o     = event_q;

endmodule
`default_nettype wire

// ===== src/midi_note_event_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note event parser
// Turns a raw MIDI byte stream into note-on and note-off events.
// ----------------------------------------------------------------------------
// Path: an accepted byte sits in the input register, then is decoded into the
// result register, where the note event it completes is presented to the sink.
// Throughput: one byte per cycle; the input register frees as its byte is
// decoded, and decoding only waits while an unclaimed event blocks the result.
// Reset: asynchronous, active low; parse state goes idle, SysEx is cleared,
// and the channel filter returns to "accept every channel".
module midi_note_event_parser_top
  import mnep_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration: channel select, signed, 0..15, negative accepts all.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [ChanW-1:0]  cfg_data_i,
  // Byte stream in.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [ByteW-1:0]  s_axis_tdata,   // [7:0] midi_byte
  // Note events out.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [TdataW-1:0]      m_axis_tdata,   // [6:0] note_number,
                                                 // [13:7] note_velocity, rest 0
  output logic                   m_axis_tuser    // [0] is_note_on
);

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             out_free;
  logic             advance;
  mnep_event_t      dec_event;
  mnep_event_t      out_event;

  // The channel register may be written at any time; the user is to write it only
  // while no request is in flight, as the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  // A held byte is decoded whenever the result register can take whatever
  // it produces. Bytes that produce nothing could go even without that, but
  // tying them together keeps the control to a single condition.
  assign advance = held_valid && out_free;

  mnep_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  mnep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .byte_i      (held_byte),
    .event_o     (dec_event)
  );

  mnep_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .event_i     (dec_event),
    .advance_i   (advance),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .event_o     (out_event)
  );

  // Pack the event: note in the low bits, velocity above it, zero padding.
  assign m_axis_tdata = {
    {(TdataW - 2 * NoteW){1'b0}},
    out_event.note_velocity,
    out_event.note_number
  };
  assign m_axis_tuser = out_event.is_note_on;

endmodule
`default_nettype wire
